// ----- hw/rtl/sta_pkg.sv -----
// Shared types, sizes and helper functions for the sorted term accumulator.
// Used by sta_ctrl, sta_dpath, the top level and the checker; no dependencies.
package sta_pkg;

    // Table geometry
    localparam int MAX_TERMS = 32;
    localparam int EXP_WIDTH = 8;
    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);

    // Fixed port widths
    localparam int OP_W       = 2;
    localparam int COEF_W     = 32;
    localparam int EXP_PORT_W = 8;
    localparam int POS_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int ENTRY_W    = COEF_W + EXP_WIDTH;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_SUB    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_CHANGED = 2'd1,
        ST_FULL    = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    // Kind of result beat to build
    typedef enum logic [2:0] {
        K_MERGE  = 3'd0,
        K_INSERT = 3'd1,
        K_FULL   = 3'd2,
        K_REMOVE = 3'd3,
        K_NONE   = 3'd4,
        K_READ   = 3'd5
    } t_kind;

    // Table write data source
    typedef enum logic [1:0] {
        W_SHIFT = 2'd0,
        W_NEW   = 2'd1,
        W_SUM   = 2'd2
    } t_wsel;

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             save_exp;
        logic             we;
        t_wsel            wsel;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
        logic             emit;
        t_kind            kind;
        logic [CNT_W-1:0] pos;
        logic             last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic gt;
        logic eq;
        logic coef_zero;
        logic out_free;
    } t_sts;

    // Saturate an exact 34-bit sum to Q16.16 range
    function automatic logic [COEF_W-1:0] sat_q(input logic [COEF_W+1:0] v);
        if (v[COEF_W+1:COEF_W-1] == 3'b000 || v[COEF_W+1:COEF_W-1] == 3'b111) begin
            return v[COEF_W-1:0];
        end else if (v[COEF_W+1]) begin
            return {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COEF_W-1){1'b1}}};
        end
    endfunction

    // Low EXP_WIDTH bits of the zero-extended exponent port
    function automatic logic [EXP_WIDTH-1:0] exp_from_port(input logic [EXP_PORT_W-1:0] p);
        logic [EXP_WIDTH+EXP_PORT_W-1:0] ext;
        ext = {{EXP_WIDTH{1'b0}}, p};
        return ext[EXP_WIDTH-1:0];
    endfunction

    // Stored exponent bits shown on the 8-bit port
    function automatic logic [EXP_PORT_W-1:0] exp_to_port(input logic [EXP_WIDTH-1:0] e);
        logic [EXP_WIDTH+EXP_PORT_W-1:0] ext;
        ext = {{EXP_PORT_W{1'b0}}, e};
        return ext[EXP_PORT_W-1:0];
    endfunction

    // One-based position resized to the port width
    function automatic logic [POS_W-1:0] pos_to_port(input logic [CNT_W-1:0] p);
        logic [CNT_W+POS_W-1:0] ext;
        ext = {{POS_W{1'b0}}, p};
        return ext[POS_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/sorted_term_accumulator_core.sv -----
// Top level of the sorted term accumulator: one sparse polynomial in a sorted term table.
// Depends on sta_pkg, sta_ctrl, sta_dpath (which holds the sta_ram table).
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | operation, term_coefficient,
//          |           |                            | term_exponent
//  out     | output    | o_out_valid / i_out_stall  | position, out_coefficient,
//          |           |                            | out_exponent, status, last
//
// One item at a time. Add/subtract accepts the item, scans for its exponent, shifts later
// entries toward the tail on an insert and replies with one beat; a miss on a full table
// replies without a shift. Remove scans for the first zero coefficient and shifts later
// entries toward the head; read gives one beat per term, one beat on an empty table. The term
// table's single read and single write port move one entry per cycle during scan and shift.
// Reset clears term count, state and output valid; entries are never read before being written.
// A stalled output holds its beat; the block waits before emitting while the slot is full.
module sorted_term_accumulator_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [sta_pkg::OP_W-1:0]              i_operation,
    input  logic signed [sta_pkg::COEF_W-1:0]     i_term_coefficient,
    input  logic signed [sta_pkg::EXP_PORT_W-1:0] i_term_exponent,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [sta_pkg::POS_W-1:0]             o_position,
    output logic signed [sta_pkg::COEF_W-1:0]     o_out_coefficient,
    output logic signed [sta_pkg::EXP_PORT_W-1:0] o_out_exponent,
    output logic [sta_pkg::STATUS_W-1:0]          o_status,
    output logic                                  o_last
);
    import sta_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    sta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Table, arithmetic and result register
    sta_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_operation        (i_operation),
        .i_term_coefficient (i_term_coefficient),
        .i_term_exponent    (i_term_exponent),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_position         (o_position),
        .o_out_coefficient  (o_out_coefficient),
        .o_out_exponent     (o_out_exponent),
        .o_status           (o_status),
        .o_last             (o_last)
    );

endmodule

// ----- hw/rtl/sta_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sta_ctrl.sv -----
// Controller state machine of the sorted term accumulator: scan, shift, read, reply.
// Depends on sta_pkg; drives the datapath through t_cmd and reads t_sts.
module sta_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [sta_pkg::OP_W-1:0]   i_operation,
    output logic                       o_in_stall,
    input  sta_pkg::t_sts              i_sts,
    output sta_pkg::t_cmd              o_cmd
);
    import sta_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_SHIFT_DN = 6'b000100,
        S_SHIFT_UP = 6'b001000,
        S_READ     = 6'b010000,
        S_REPLY    = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_count, n_count;
    t_kind            r_kind, n_kind;
    logic             r_remove, n_remove;
    t_cmd             cmd;

    logic [CNT_W-1:0] w_idx_inc;
    logic [CNT_W-1:0] w_idx_dec;
    logic [CNT_W-1:0] w_pos_inc;
    logic             w_full;
    logic             w_at_end;

    assign w_idx_inc = r_idx + CNT_W'(1);
    assign w_idx_dec = r_idx - CNT_W'(1);
    assign w_pos_inc = r_pos + CNT_W'(1);
    assign w_full    = (r_count == CNT_W'(MAX_TERMS));
    assign w_at_end  = (r_idx == r_count);

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_count  = r_count;
        n_kind   = r_kind;
        n_remove = r_remove;
        cmd      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_idx    = '0;
                    n_remove = (t_op'(i_operation) == OP_REMOVE);
                    n_state  = (t_op'(i_operation) == OP_READ) ? S_READ : S_SCAN;
                end
            end
            S_SCAN: begin
                // RAM output holds entry r_idx
                if (w_at_end) begin
                    n_pos   = r_idx;
                    n_state = S_REPLY;
                    if (r_remove) begin
                        n_kind = K_NONE;
                    end else if (w_full) begin
                        n_kind = K_FULL;
                    end else begin
                        n_kind = K_INSERT;
                    end
                end else if (r_remove) begin
                    if (i_sts.coef_zero) begin
                        n_pos        = r_idx;
                        cmd.save_exp = 1'b1;
                        if (w_idx_inc == r_count) begin
                            n_kind  = K_REMOVE;
                            n_state = S_REPLY;
                        end else begin
                            n_idx   = w_idx_inc;
                            n_state = S_SHIFT_UP;
                        end
                    end else begin
                        n_idx = w_idx_inc;
                    end
                end else if (i_sts.gt) begin
                    n_idx = w_idx_inc;
                end else if (i_sts.eq) begin
                    n_pos   = r_idx;
                    n_kind  = K_MERGE;
                    n_state = S_REPLY;
                end else begin
                    // New exponent goes in front of entry r_idx
                    n_pos = r_idx;
                    if (w_full) begin
                        n_kind  = K_FULL;
                        n_state = S_REPLY;
                    end else begin
                        n_idx   = r_count - CNT_W'(1);
                        n_state = S_SHIFT_DN;
                    end
                end
            end
            S_SHIFT_DN: begin
                // Move entry r_idx one place toward the tail
                cmd.we    = 1'b1;
                cmd.wsel  = W_SHIFT;
                cmd.waddr = w_idx_inc[IDX_W-1:0];
                if (r_idx == r_pos) begin
                    n_kind  = K_INSERT;
                    n_state = S_REPLY;
                end else begin
                    n_idx = w_idx_dec;
                end
            end
            S_SHIFT_UP: begin
                // Move entry r_idx one place toward the head
                cmd.we    = 1'b1;
                cmd.wsel  = W_SHIFT;
                cmd.waddr = w_idx_dec[IDX_W-1:0];
                if (w_idx_inc == r_count) begin
                    n_kind  = K_REMOVE;
                    n_state = S_REPLY;
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            S_READ: begin
                if (r_count == '0) begin
                    n_pos   = '0;
                    n_kind  = K_NONE;
                    n_state = S_REPLY;
                end else if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = K_READ;
                    cmd.pos  = w_idx_inc;
                    cmd.last = (w_idx_inc == r_count);
                    if (w_idx_inc == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = w_idx_inc;
                    end
                end
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = r_kind;
                    cmd.pos  = w_pos_inc;
                    cmd.last = 1'b1;
                    n_state  = S_IDLE;
                    case (r_kind)
                        K_MERGE: begin
                            cmd.we    = 1'b1;
                            cmd.wsel  = W_SUM;
                            cmd.waddr = r_pos[IDX_W-1:0];
                        end
                        K_INSERT: begin
                            cmd.we    = 1'b1;
                            cmd.wsel  = W_NEW;
                            cmd.waddr = r_pos[IDX_W-1:0];
                            n_count   = r_count + CNT_W'(1);
                        end
                        K_REMOVE: begin
                            n_count = r_count - CNT_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Read address follows the next index so RAM data tracks r_idx
        cmd.raddr = n_idx[IDX_W-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_pos    <= '0;
            r_count  <= '0;
            r_kind   <= K_NONE;
            r_remove <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_kind   <= n_kind;
            r_remove <= n_remove;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

endmodule

// ----- hw/rtl/sta_dpath.sv -----
// Datapath of the sorted term accumulator: item registers, term table RAM,
// saturating adder, compares and the output register. Depends on sta_pkg, sta_ram.
module sta_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [sta_pkg::OP_W-1:0]           i_operation,
    input  logic signed [sta_pkg::COEF_W-1:0]  i_term_coefficient,
    input  logic signed [sta_pkg::EXP_PORT_W-1:0] i_term_exponent,
    input  sta_pkg::t_cmd                      i_cmd,
    output sta_pkg::t_sts                      o_sts,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [sta_pkg::POS_W-1:0]          o_position,
    output logic signed [sta_pkg::COEF_W-1:0]  o_out_coefficient,
    output logic signed [sta_pkg::EXP_PORT_W-1:0] o_out_exponent,
    output logic [sta_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_last
);
    import sta_pkg::*;

    // Item registers
    logic [COEF_W:0]      r_delta, n_delta;
    logic [EXP_WIDTH-1:0] r_exp;
    logic [EXP_WIDTH-1:0] r_saved_exp;

    // Output register
    logic                  r_out_valid;
    logic [POS_W-1:0]      r_position, n_position;
    logic [COEF_W-1:0]     r_coef, n_coef;
    logic [EXP_PORT_W-1:0] r_exp_out, n_exp_out;
    t_status               r_status, n_status;
    logic                  r_last;

    logic [ENTRY_W-1:0]   w_rdata;
    logic [ENTRY_W-1:0]   w_wdata;
    logic [COEF_W-1:0]    w_rd_coef;
    logic [EXP_WIDTH-1:0] w_rd_exp;
    logic [COEF_W+1:0]    w_sum;
    logic [COEF_W-1:0]    w_sum_sat;
    logic [COEF_W-1:0]    w_new_sat;
    logic [COEF_W:0]      w_cext;

    assign w_rd_coef = w_rdata[EXP_WIDTH +: COEF_W];
    assign w_rd_exp  = w_rdata[EXP_WIDTH-1:0];

    // Signed delta: subtract negates the coefficient exactly
    assign w_cext  = {i_term_coefficient[COEF_W-1], i_term_coefficient};
    assign n_delta = (t_op'(i_operation) == OP_SUB) ? (~w_cext + (COEF_W+1)'(1)) : w_cext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_delta <= n_delta;
            r_exp   <= exp_from_port(i_term_exponent);
        end
        if (i_cmd.save_exp) begin
            r_saved_exp <= w_rd_exp;
        end
    end

    // Saturating merge and insert values
    assign w_sum     = {{2{w_rd_coef[COEF_W-1]}}, w_rd_coef} + {r_delta[COEF_W], r_delta};
    assign w_sum_sat = sat_q(w_sum);
    assign w_new_sat = sat_q({r_delta[COEF_W], r_delta});

    // Table write data
    always_comb begin
        case (i_cmd.wsel)
            W_SHIFT: w_wdata = w_rdata;
            W_NEW:   w_wdata = {w_new_sat, r_exp};
            W_SUM:   w_wdata = {w_sum_sat, r_exp};
            default: w_wdata = w_rdata;
        endcase
    end

    sta_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TERMS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_waddr (i_cmd.waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_cmd.raddr),
        .o_rdata (w_rdata)
    );

    // Status back to the controller
    assign o_sts.gt        = ($signed(w_rd_exp) > $signed(r_exp));
    assign o_sts.eq        = (w_rd_exp == r_exp);
    assign o_sts.coef_zero = (w_rd_coef == '0);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // Result beat contents
    always_comb begin
        n_position = pos_to_port(i_cmd.pos);
        n_coef     = '0;
        n_exp_out  = '0;
        n_status   = ST_NONE;
        case (i_cmd.kind)
            K_MERGE: begin
                n_coef    = w_sum_sat;
                n_exp_out = exp_to_port(r_exp);
                n_status  = ST_DONE;
            end
            K_INSERT: begin
                n_coef    = w_new_sat;
                n_exp_out = exp_to_port(r_exp);
                n_status  = ST_CHANGED;
            end
            K_FULL: begin
                n_position = '0;
                n_status   = ST_FULL;
            end
            K_REMOVE: begin
                n_exp_out = exp_to_port(r_saved_exp);
                n_status  = ST_CHANGED;
            end
            K_READ: begin
                n_coef    = w_rd_coef;
                n_exp_out = exp_to_port(w_rd_exp);
                n_status  = ST_DONE;
            end
            default: begin
                n_position = '0;
                n_status   = ST_NONE;
            end
        endcase
    end

    // Output register; controller emits only when the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_position <= n_position;
            r_coef     <= n_coef;
            r_exp_out  <= n_exp_out;
            r_status   <= n_status;
            r_last     <= i_cmd.last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_position        = r_position;
    assign o_out_coefficient = r_coef;
    assign o_out_exponent    = r_exp_out;
    assign o_status          = r_status;
    assign o_last            = r_last;

endmodule

// ----- hw/rtl/sta_checker.sv -----
// Port-level checks for sorted_term_accumulator_core, attached by bind.
// Depends on sta_pkg and the top level's port list.
module sta_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic [sta_pkg::OP_W-1:0]              i_operation,
    input logic signed [sta_pkg::COEF_W-1:0]     i_term_coefficient,
    input logic signed [sta_pkg::EXP_PORT_W-1:0] i_term_exponent,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic [sta_pkg::POS_W-1:0]             o_position,
    input logic signed [sta_pkg::COEF_W-1:0]     o_out_coefficient,
    input logic signed [sta_pkg::EXP_PORT_W-1:0] o_out_exponent,
    input logic [sta_pkg::STATUS_W-1:0]          o_status,
    input logic                                  o_last
);
    import sta_pkg::*;

    // A stalled result beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_position) && $stable(o_out_coefficient)
            && $stable(o_out_exponent) && $stable(o_status) && $stable(o_last))
        else $error("result payload changed while stalled");

    // An accepted beat keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after an accept");

    // Full table or nothing found: single beat at position zero
    a_fail_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL || o_status == ST_NONE)
            |-> o_position == '0 && o_last)
        else $error("failure beat with a position or without last");

    // Merged, inserted, removed or read terms always name a table position
    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_DONE || o_status == ST_CHANGED)
            |-> o_position != '0)
        else $error("term beat without a table position");

endmodule

bind sorted_term_accumulator_core sta_checker u_sta_checker (.*);

// ----- dv/sta_term_checker.sv -----
// Checker for the sorted term accumulator: watches both channels, keeps its own
// sorted term table, predicts each result beat and compares. Depends on sta_pkg.
module sta_term_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_stall,
    input  logic [sta_pkg::OP_W-1:0]              i_operation,
    input  logic signed [sta_pkg::COEF_W-1:0]     i_term_coefficient,
    input  logic signed [sta_pkg::EXP_PORT_W-1:0] i_term_exponent,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic [sta_pkg::POS_W-1:0]             i_position,
    input  logic signed [sta_pkg::COEF_W-1:0]     i_out_coefficient,
    input  logic signed [sta_pkg::EXP_PORT_W-1:0] i_out_exponent,
    input  logic [sta_pkg::STATUS_W-1:0]          i_status,
    input  logic                                  i_last,
    output logic [31:0]                           o_errors,
    output logic [31:0]                           o_pending
);
    import sta_pkg::*;

    typedef struct {
        logic [POS_W-1:0]      pos;
        logic [COEF_W-1:0]     coef;
        logic [EXP_PORT_W-1:0] ex;
        logic [STATUS_W-1:0]   status;
        logic                  last;
    } t_term_beat;

    // Shadow polynomial, kept in falling exponent order
    logic signed [COEF_W-1:0]    shadow_coef [MAX_TERMS];
    logic signed [EXP_WIDTH-1:0] shadow_exp  [MAX_TERMS];
    int                          shadow_count = 0;
    t_term_beat                  expected_beats [$];
    int                          err_count = 0;

    assign o_errors = err_count;

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 100) begin
            $display("[%0t] checker: %s", $realtime, msg);
        end
    endtask

    function automatic logic signed [COEF_W-1:0] clamp_q(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return COEF_W'(v);
    endfunction

    task automatic push_beat(input int pos, input logic signed [COEF_W-1:0] coef,
                             input logic signed [EXP_WIDTH-1:0] ex, input t_status st,
                             input logic last);
        t_term_beat b;
        b.pos    = POS_W'(pos);
        b.coef   = coef;
        b.ex     = EXP_PORT_W'({1'b0, ex});
        b.status = st;
        b.last   = last;
        expected_beats.push_back(b);
    endtask

    // Add or subtract one term: merge if the exponent is there, else insert in order
    task automatic merge_term(input longint delta, input logic signed [EXP_WIDTH-1:0] ex);
        int i;
        i = 0;
        while (i < shadow_count && shadow_exp[i] > ex) i++;
        if (i < shadow_count && shadow_exp[i] == ex) begin
            shadow_coef[i] = clamp_q(longint'(shadow_coef[i]) + delta);
            push_beat(i + 1, shadow_coef[i], ex, ST_DONE, 1'b1);
        end else if (shadow_count >= MAX_TERMS) begin
            push_beat(0, '0, '0, ST_FULL, 1'b1);
        end else begin
            for (int j = shadow_count; j > i; j--) begin
                shadow_coef[j] = shadow_coef[j-1];
                shadow_exp[j]  = shadow_exp[j-1];
            end
            shadow_coef[i] = clamp_q(delta);
            shadow_exp[i]  = ex;
            shadow_count++;
            push_beat(i + 1, shadow_coef[i], ex, ST_CHANGED, 1'b1);
        end
    endtask

    // Drop the first zero-coefficient term, later terms move up
    task automatic remove_zero_term();
        int i;
        logic signed [EXP_WIDTH-1:0] ex;
        i = 0;
        while (i < shadow_count && shadow_coef[i] != 0) i++;
        if (i >= shadow_count) begin
            push_beat(0, '0, '0, ST_NONE, 1'b1);
        end else begin
            ex = shadow_exp[i];
            for (int j = i; j + 1 < shadow_count; j++) begin
                shadow_coef[j] = shadow_coef[j+1];
                shadow_exp[j]  = shadow_exp[j+1];
            end
            shadow_count--;
            push_beat(i + 1, '0, ex, ST_CHANGED, 1'b1);
        end
    endtask

    task automatic apply_term_op(input t_op op, input logic signed [COEF_W-1:0] c,
                                 input logic signed [EXP_WIDTH-1:0] ex);
        case (op)
            OP_ADD:    merge_term(longint'(c), ex);
            OP_SUB:    merge_term(-longint'(c), ex);
            OP_REMOVE: remove_zero_term();
            default: begin
                if (shadow_count == 0) begin
                    push_beat(0, '0, '0, ST_NONE, 1'b1);
                end else begin
                    for (int k = 0; k < shadow_count; k++) begin
                        push_beat(k + 1, shadow_coef[k], shadow_exp[k], ST_DONE,
                                  k + 1 == shadow_count);
                    end
                end
            end
        endcase
    endtask

    task automatic check_beat();
        t_term_beat exp_b;
        if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat pos=%0d coef=%h exp=%h st=%0d last=%0b",
                                      i_position, i_out_coefficient, i_out_exponent,
                                      i_status, i_last));
            return;
        end
        exp_b = expected_beats.pop_front();
        if (i_position !== exp_b.pos || i_out_coefficient !== exp_b.coef ||
            i_out_exponent !== exp_b.ex || i_status !== exp_b.status ||
            i_last !== exp_b.last) begin
            report_mismatch($sformatf(
                "got pos=%0d coef=%h exp=%h st=%0d last=%0b, want %0d %h %h %0d %0b",
                i_position, i_out_coefficient, i_out_exponent, i_status, i_last,
                exp_b.pos, exp_b.coef, exp_b.ex, exp_b.status, exp_b.last));
        end
    endtask

    // Output beats are checked before the new input is folded in; an item never
    // answers at the edge that accepts it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_beats.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_beat();
            if (i_in_valid && !i_in_stall) begin
                apply_term_op(t_op'(i_operation), i_term_coefficient,
                              i_term_exponent[EXP_WIDTH-1:0]);
            end
        end
        o_pending <= expected_beats.size();
    end

endmodule

// ----- dv/sorted_term_accumulator_core_tb.sv -----
// Testbench top for sorted_term_accumulator_core: drives term beats, random stalls
// and a long output hold-off. Depends on sta_pkg, the RTL and sta_term_checker.
module sorted_term_accumulator_core_tb;
    import sta_pkg::*;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    t_op                          operation;
    logic signed [COEF_W-1:0]     term_coef;
    logic signed [EXP_PORT_W-1:0] term_exp;
    logic                         out_valid;
    logic                         out_stall;
    logic [POS_W-1:0]             position;
    logic signed [COEF_W-1:0]     out_coef;
    logic signed [EXP_PORT_W-1:0] out_exp;
    logic [STATUS_W-1:0]          status;
    logic                         last;
    logic [31:0]                  mismatches;
    logic [31:0]                  beats_owed;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_go;
    bit hold_done;

    sorted_term_accumulator_core DUT (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_operation        (operation),
        .i_term_coefficient (term_coef),
        .i_term_exponent    (term_exp),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_position         (position),
        .o_out_coefficient  (out_coef),
        .o_out_exponent     (out_exp),
        .o_status           (status),
        .o_last             (last)
    );

    sta_term_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_operation        (operation),
        .i_term_coefficient (term_coef),
        .i_term_exponent    (term_exp),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_position         (position),
        .i_out_coefficient  (out_coef),
        .i_out_exponent     (out_exp),
        .i_status           (status),
        .i_last             (last),
        .o_errors           (mismatches),
        .o_pending          (beats_owed)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output side: random stall, plus one long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_go && !hold_done) begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // One input beat, with random idle cycles ahead of it; returns at a falling edge
    task automatic send_term(input t_op op, input logic signed [COEF_W-1:0] c,
                             input logic signed [EXP_PORT_W-1:0] e);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        term_coef <= c;
        term_exp  <= e;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly small coefficients and a narrow exponent pool so terms merge, cancel,
    // get removed and the table fills; the rest is full-range noise and extremes
    task automatic send_random_term();
        t_op                          op;
        logic signed [COEF_W-1:0]     c;
        logic signed [EXP_PORT_W-1:0] e;
        int                           r;
        r = $urandom_range(99);
        if (r < 45)      op = OP_ADD;
        else if (r < 70) op = OP_SUB;
        else if (r < 85) op = OP_REMOVE;
        else             op = OP_READ;
        r = $urandom_range(99);
        if (r < 45) begin
            c = (int'($urandom_range(4)) - 2) * 32'sh0001_0000;
        end else if (r < 55) begin
            case ($urandom_range(4))
                0:       c = 32'sh7FFF_FFFF;
                1:       c = 32'sh8000_0000;
                2:       c = 32'sh0000_0001;
                3:       c = 32'shFFFF_FFFF;
                default: c = '0;
            endcase
        end else begin
            c = $urandom();
        end
        r = $urandom_range(99);
        if (r < 70) begin
            e = EXP_PORT_W'(int'($urandom_range(47)) - 24);
        end else if (r < 85) begin
            e = EXP_PORT_W'($urandom());
        end else begin
            case ($urandom_range(3))
                0:       e = 8'sd127;
                1:       e = -8'sd128;
                2:       e = 8'sd0;
                default: e = -8'sd1;
            endcase
        end
        send_term(op, c, e);
    endtask

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = OP_ADD;
        term_coef      = '0;
        term_exp       = '0;
        send_idle_pct  = 16;
        recv_stall_pct = 51;
        hold_go        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty table, saturation both ways, negation of the minimum,
        // merge to zero, removals, bit patterns, reads
        send_term(OP_READ,   $urandom(), EXP_PORT_W'($urandom()));
        send_term(OP_REMOVE, $urandom(), EXP_PORT_W'($urandom()));
        send_term(OP_ADD, 32'sh7FFF_FFFF, 8'sd127);
        send_term(OP_ADD, 32'sh7FFF_FFFF, 8'sd127);
        send_term(OP_ADD, 32'sh8000_0000, -8'sd128);
        send_term(OP_SUB, 32'sh7FFF_FFFF, -8'sd128);
        send_term(OP_SUB, 32'sh8000_0000, 8'sd0);
        send_term(OP_ADD, 32'sh0001_0000, 8'sd5);
        send_term(OP_SUB, 32'sh0001_0000, 8'sd5);
        send_term(OP_ADD, 32'sh0000_0000, -8'sd1);
        send_term(OP_READ,   $urandom(), EXP_PORT_W'($urandom()));
        send_term(OP_REMOVE, $urandom(), EXP_PORT_W'($urandom()));
        send_term(OP_REMOVE, $urandom(), EXP_PORT_W'($urandom()));
        send_term(OP_REMOVE, $urandom(), EXP_PORT_W'($urandom()));
        send_term(OP_ADD, 32'sh0000_0001, 8'sd0);
        send_term(OP_SUB, 32'shFFFF_FFFF, 8'sd64);
        send_term(OP_ADD, 32'sh5555_5555, 8'sh55);
        send_term(OP_ADD, 32'shAAAA_AAAA, 8'shAA);
        send_term(OP_SUB, 32'sh8000_0000, 8'sh55);
        send_term(OP_READ,   $urandom(), EXP_PORT_W'($urandom()));

        // Random, three stall profiles
        repeat (67) send_random_term();
        send_idle_pct  = 51;
        recv_stall_pct = 16;
        hold_go        = 1'b1;
        repeat (67) send_random_term();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (67) send_random_term();
        send_term(OP_READ, $urandom(), EXP_PORT_W'($urandom()));
        in_valid <= 1'b0;

        // Drain, then a margin for any stray beat
        @(posedge clk);
        while (beats_owed != 0) @(posedge clk);
        repeat (2 * MAX_TERMS + 16) @(posedge clk);
        if (mismatches == 0 && beats_owed == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/sta_pkg.sv
hw/rtl/sta_ram.sv
hw/rtl/sta_ctrl.sv
hw/rtl/sta_dpath.sv
hw/rtl/sorted_term_accumulator_core.sv
hw/rtl/sta_checker.sv
dv/sta_term_checker.sv
dv/sorted_term_accumulator_core_tb.sv
